FILE: src/assert_macros.svh
// Assertion macros shared by the training step RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, sampled on clock, off during reset.
`define WETS_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("wets assertion failed");
// Next-cycle implication, sampled on clock, off during reset.
`define WETS_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("wets assertion failed");
`endif

FILE: src/wets_pkg.sv
// Types, constants and helper functions for the word embedding training step.
package wets_pkg;

   localparam int WORD_W    = 10;
   localparam int COL_W     = 16;
   localparam int LR_W      = 20;
   localparam int ERR_W     = 18;
   localparam int E_W       = 17;
   localparam int DIV_QBITS = 17;
   localparam int DIV_NW    = 34;
   localparam int CNT_W     = 8;
   localparam int EXP_N_LIMIT = 12;

   localparam logic signed [31:0] HALF_Q16  = 32'sd32768;
   localparam logic signed [31:0] SCORE_LOW = -32'sd65536;
   localparam logic [LR_W-1:0]    LR_RESET  = 20'd6554;

   typedef struct packed {
      logic [WORD_W-1:0] input_word;
      logic [WORD_W-1:0] output_word;
   } req_type;

   typedef struct packed {
      logic [CNT_W-1:0] positive_change_count;
      logic [CNT_W-1:0] nonpositive_change_count;
   } rsp_type;

   // Item travelling down the row of cells
   typedef struct packed {
      logic                    score;
      logic                    grad;
      logic [COL_W-1:0]        col;
      logic signed [ERR_W-1:0] err;
      logic signed [63:0]      psum;
   } chain_type;

   // Broadcast controls from the sequencer to every cell
   typedef struct packed {
      logic                    clr_we;
      logic [COL_W-1:0]        clr_addr;
      logic                    load_h;
      logic                    clr_acc;
      logic [COL_W-1:0]        row;
      logic [COL_W-1:0]        col_t;
      logic signed [ERR_W-1:0] e_t;
      logic [LR_W-1:0]         lr;
      logic                    mul_e;
      logic                    rnd;
      logic                    mul_lr;
      logic                    wr;
   } cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] pos;
      logic [CNT_W-1:0] neg;
   } cnt_type;

   typedef struct packed {
      logic                 valid;
      logic [COL_W-1:0]     col;
      logic [DIV_NW-1:0]    rem;
      logic [DIV_QBITS-1:0] q;
   } div_type;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_LOAD, ST_SCORE, ST_EXP, ST_PROB, ST_UPDATE, ST_DONE
   } state_type;

   // exp(-n) in Q1.16
   function automatic logic [E_W-1:0] exp_whole(input logic [3:0] n);
      logic [E_W-1:0] r;
      case (n)
         4'd0:    r = 17'd65536;
         4'd1:    r = 17'd24109;
         4'd2:    r = 17'd8869;
         4'd3:    r = 17'd3263;
         4'd4:    r = 17'd1200;
         4'd5:    r = 17'd442;
         4'd6:    r = 17'd162;
         4'd7:    r = 17'd60;
         4'd8:    r = 17'd22;
         4'd9:    r = 17'd8;
         4'd10:   r = 17'd3;
         4'd11:   r = 17'd1;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

   // exp(-k/16) in Q1.16
   function automatic logic [E_W-1:0] exp_frac(input logic [3:0] k);
      logic [E_W-1:0] r;
      case (k)
         4'd0:    r = 17'd65536;
         4'd1:    r = 17'd61565;
         4'd2:    r = 17'd57835;
         4'd3:    r = 17'd54331;
         4'd4:    r = 17'd51039;
         4'd5:    r = 17'd47947;
         4'd6:    r = 17'd45042;
         4'd7:    r = 17'd42313;
         4'd8:    r = 17'd39750;
         4'd9:    r = 17'd37341;
         4'd10:   r = 17'd35079;
         4'd11:   r = 17'd32954;
         4'd12:   r = 17'd30957;
         4'd13:   r = 17'd29081;
         4'd14:   r = 17'd27319;
         default: r = 17'd25664;
      endcase
      return r;
   endfunction

   // Round half up to Q16.16: floor((v + 2^15) / 2^16)
   function automatic logic signed [79:0] rnd16(input logic signed [79:0] v);
      logic signed [79:0] t;
      t = v + 80'sd32768;
      return t >>> 16;
   endfunction

   // Saturate to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
      logic signed [31:0] r;
      if (v > 80'sd2147483647)
         r = 32'sh7fffffff;
      else if (v < -80'sd2147483648)
         r = 32'sh80000000;
      else
         r = v[31:0];
      return r;
   endfunction

endpackage

FILE: src/wets_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wets_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

FILE: src/wets_div.sv
// Pipelined restoring divider, one quotient bit per stage, one request per cycle.
module wets_div #(
   parameter int SUM_W = 27
) (
   input  logic                    clock,
   input  logic                    reset,
   input  wets_pkg::div_type       div_in,
   input  logic [SUM_W-1:0]        divisor,
   output wets_pkg::div_type       div_out
);
   import wets_pkg::*;

   localparam int DW   = SUM_W + DIV_QBITS;
   localparam int CMPW = (DW > DIV_NW) ? DW : DIV_NW;

   div_type st_ff [DIV_QBITS];

   genvar s;
   generate
      for (s = 0; s < DIV_QBITS; s++) begin : g_stage
         div_type        prev;
         div_type        st_in;
         logic [CMPW-1:0] rem_x;
         logic [CMPW-1:0] dsh;

         if (s == 0) begin : g_first
            assign prev = div_in;
         end else begin : g_next
            assign prev = st_ff[s-1];
         end

         // trial subtract of divisor shifted to this quotient bit
         always_comb begin
            rem_x = CMPW'(prev.rem);
            dsh   = CMPW'(divisor) << (DIV_QBITS - 1 - s);
            st_in = prev;
            if (rem_x >= dsh) begin
               st_in.rem = DIV_NW'(rem_x - dsh);
               st_in.q[DIV_QBITS-1-s] = 1'b1;
            end else begin
               st_in.q[DIV_QBITS-1-s] = 1'b0;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               st_ff[s] <= '0;
            end else begin
               st_ff[s] <= st_in;
            end
         end
      end
   endgenerate

   assign div_out = st_ff[DIV_QBITS-1];
endmodule

FILE: src/wets_cell.sv
// One hidden unit: its output-weight row, input-weight column and update datapath.
module wets_cell #(
   parameter int VOCAB_SIZE = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  wets_pkg::cmd_type   cmd,
   input  wets_pkg::chain_type chain_in,
   output wets_pkg::chain_type chain_out,
   input  wets_pkg::cnt_type   cnt_in,
   output wets_pkg::cnt_type   cnt_out
);
   import wets_pkg::*;

   localparam int AW    = $clog2(VOCAB_SIZE);
   localparam int ACC_W = 50 + AW;

   chain_type s1_ff, s2_ff, out_ff, out_in;
   cnt_type   cnt_ff;

   logic signed [31:0]      h_ff;
   logic signed [63:0]      prod_ff;
   logic signed [ACC_W-1:0] eh_acc_ff;
   logic signed [49:0]      uprod_ff;
   logic signed [31:0]      cout_ff, cin_ff;
   logic signed [52:0]      stepo_ff, stepi_ff;
   logic                    pos_o_ff, pos_i_ff;

   logic [31:0]        ow_rdata, iw_rdata;
   logic signed [31:0] ow_rd, mul_b;
   logic [AW-1:0]      ow_raddr, ow_waddr, iw_waddr;
   logic               ow_we, iw_we;
   logic [31:0]        ow_wdata, iw_wdata;
   logic signed [79:0] prod_rnd, stepo_rnd, stepi_rnd;
   logic signed [31:0] new_o, new_i;
   logic signed [20:0] lr_s;

   // Weight stores for this hidden unit
   wets_ram #(.WIDTH(32), .DEPTH(VOCAB_SIZE)) u_ow_ram (
      .clock (clock),
      .we    (ow_we),
      .waddr (ow_waddr),
      .wdata (ow_wdata),
      .raddr (ow_raddr),
      .rdata (ow_rdata)
   );

   wets_ram #(.WIDTH(32), .DEPTH(VOCAB_SIZE)) u_iw_ram (
      .clock (clock),
      .we    (iw_we),
      .waddr (iw_waddr),
      .wdata (iw_wdata),
      .raddr (cmd.row[AW-1:0]),
      .rdata (iw_rdata)
   );

   assign ow_rd = $signed(ow_rdata);
   assign lr_s  = $signed({1'b0, cmd.lr});

   // Read address follows the stream, else the target column
   assign ow_raddr = (chain_in.score || chain_in.grad) ? chain_in.col[AW-1:0]
                                                       : cmd.col_t[AW-1:0];
   assign mul_b    = s1_ff.score ? h_ff : 32'(s1_ff.err);
   assign prod_rnd = rnd16(80'(prod_ff));

   // Add this unit's rounded product to a passing score
   always_comb begin
      out_in = s2_ff;
      if (s2_ff.score) begin
         out_in.psum = s2_ff.psum + prod_rnd[63:0];
      end
   end

   // New weights after one scaled step
   assign stepo_rnd = rnd16(80'(stepo_ff));
   assign stepi_rnd = rnd16(80'(stepi_ff));
   assign new_o     = sat32(80'(ow_rd) - stepo_rnd);
   assign new_i     = sat32(80'(h_ff) - stepi_rnd);

   // Write ports: clearing pass or update
   assign ow_we    = cmd.clr_we || cmd.wr;
   assign iw_we    = cmd.clr_we || cmd.wr;
   assign ow_waddr = cmd.clr_we ? cmd.clr_addr[AW-1:0] : cmd.col_t[AW-1:0];
   assign iw_waddr = cmd.clr_we ? cmd.clr_addr[AW-1:0] : cmd.row[AW-1:0];
   assign ow_wdata = cmd.clr_we ? HALF_Q16 : new_o;
   assign iw_wdata = cmd.clr_we ? HALF_Q16 : new_i;

   // Stream stages: read, multiply, accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff  <= '0;
         s2_ff  <= '0;
         out_ff <= '0;
         cnt_ff <= '0;
      end else begin
         s1_ff  <= chain_in;
         s2_ff  <= s1_ff;
         out_ff <= out_in;
         cnt_ff.pos <= CNT_W'(cnt_in.pos + CNT_W'(pos_o_ff) + CNT_W'(pos_i_ff));
         cnt_ff.neg <= CNT_W'(cnt_in.neg + CNT_W'(!pos_o_ff) + CNT_W'(!pos_i_ff));
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= ow_rd * mul_b;
      if (cmd.load_h) begin
         h_ff <= $signed(iw_rdata);
      end
      if (cmd.clr_acc) begin
         eh_acc_ff <= '0;
      end else if (s2_ff.grad) begin
         eh_acc_ff <= eh_acc_ff + ACC_W'(prod_ff);
      end
      if (cmd.mul_e) begin
         uprod_ff <= cmd.e_t * h_ff;
      end
      if (cmd.rnd) begin
         cout_ff <= sat32(rnd16(80'(uprod_ff)));
         cin_ff  <= sat32(rnd16(80'(eh_acc_ff)));
      end
      if (cmd.mul_lr) begin
         stepo_ff <= lr_s * cout_ff;
         stepi_ff <= lr_s * cin_ff;
         pos_o_ff <= (cout_ff > 32'sd0);
         pos_i_ff <= (cin_ff > 32'sd0);
      end
   end

   assign chain_out = out_ff;
   assign cnt_out   = cnt_ff;
endmodule

FILE: src/word_embedding_training_step_core.sv
// Word embedding training step: top level with sequencer, score store and cell row.
//
// Usage: a request carries an input word and an output word (req_valid/req_ready).
// One response per request carries the counts of positive and non-positive weight
// changes (rsp_valid/rsp_ready). The learning rate is written through csr_we and
// csr_wdata while the block is idle; it takes effect on the next request.
// After reset a clearing pass sets every weight to 0.5, one vocabulary entry of all
// cells per cycle, with req_ready low.
// A request makes three passes over the vocabulary, one entry per cycle: scores
// streamed through the row of HIDDEN_SIZE cells, exponentials computed from the
// score store, and probabilities through the 17-stage divider and then the row
// with gradient accumulation; the count chain follows. One request is in work
// at a time. A request with a word index beyond the vocabulary is answered
// with zero counts and no change. The finished response sits in an output
// register; a new request is accepted while it waits, and a further response
// waits for rsp_ready.
`include "assert_macros.svh"
module word_embedding_training_step_core #(
   parameter int VOCAB_SIZE  = 1024,
   parameter int HIDDEN_SIZE = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  wets_pkg::req_type             req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output wets_pkg::rsp_type             rsp_payload,
   input  logic                          csr_we,
   input  logic [wets_pkg::LR_W-1:0]     csr_wdata
);
   import wets_pkg::*;

   localparam int AW    = $clog2(VOCAB_SIZE);
   localparam int SUM_W = E_W + AW;
   localparam int CW    = $clog2(VOCAB_SIZE + HIDDEN_SIZE + 8) + 1;
   localparam logic [CW-1:0]    VCNT   = CW'(VOCAB_SIZE);
   localparam logic [COL_W-1:0] LASTC  = COL_W'(VOCAB_SIZE - 1);
   localparam logic [CW-1:0]    UPD_END = CW'(HIDDEN_SIZE + 3);

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   logic [LR_W-1:0]         lr_ff;
   logic [COL_W-1:0]        row_ff, colt_ff;
   logic signed [31:0]      top_ff;
   logic [SUM_W-1:0]        total_ff;
   logic signed [ERR_W-1:0] e_t_ff;
   rsp_type                 res_ff, rsp_ff;
   logic                    rsp_valid_ff;
   chain_type               inject_ff, inject_in;
   logic                    rd_v_ff, ev1_ff;
   logic [COL_W-1:0]        rd_col_ff, ecol1_ff;
   logic [33:0]             eprod_ff;

   cmd_type   cmd;
   chain_type chain [HIDDEN_SIZE+1];
   cnt_type   cnts  [HIDDEN_SIZE+1];
   div_type   div_in, div_out;

   logic               accept, bad_word, take_rsp, score_done, exp_done, prob_done;
   logic               ss_we;
   logic [AW-1:0]      ss_waddr;
   logic [31:0]        ss_wdata, ss_rdata;
   logic signed [31:0] score_sat;
   logic signed [32:0] ediff;
   logic [16:0]        e_val;
   logic [E_W-1:0]     p_val;
   logic signed [ERR_W-1:0] err_val;

   // Row of cells
   assign chain[0] = inject_ff;
   assign cnts[0]  = '0;

   genvar g;
   generate
      for (g = 0; g < HIDDEN_SIZE; g++) begin : g_cell
         wets_cell #(.VOCAB_SIZE(VOCAB_SIZE)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .cmd       (cmd),
            .chain_in  (chain[g]),
            .chain_out (chain[g+1]),
            .cnt_in    (cnts[g]),
            .cnt_out   (cnts[g+1])
         );
      end
   endgenerate

   // Score / exponential store
   wets_ram #(.WIDTH(32), .DEPTH(VOCAB_SIZE)) u_score_ram (
      .clock (clock),
      .we    (ss_we),
      .waddr (ss_waddr),
      .wdata (ss_wdata),
      .raddr (cnt_ff[AW-1:0]),
      .rdata (ss_rdata)
   );

   wets_div #(.SUM_W(SUM_W)) u_div (
      .clock   (clock),
      .reset   (reset),
      .div_in  (div_in),
      .divisor (total_ff),
      .div_out (div_out)
   );

   assign accept     = req_valid && req_ready;
   assign bad_word   = ({22'd0, req_payload.input_word} >= 32'(VOCAB_SIZE)) ||
                       ({22'd0, req_payload.output_word} >= 32'(VOCAB_SIZE));
   assign take_rsp   = !rsp_valid_ff || rsp_ready;
   assign score_done = chain[HIDDEN_SIZE].score && (chain[HIDDEN_SIZE].col == LASTC);
   assign exp_done   = ev1_ff && (ecol1_ff == LASTC);
   assign prob_done  = chain[HIDDEN_SIZE].grad && (chain[HIDDEN_SIZE].col == LASTC);

   // Score store write: scores in the first pass, exponentials in the second
   assign score_sat = sat32(80'(chain[HIDDEN_SIZE].psum));
   assign e_val     = 17'((eprod_ff + 34'd32768) >> 16);
   assign ss_we     = (state_ff == ST_SCORE) ? chain[HIDDEN_SIZE].score : ev1_ff;
   assign ss_waddr  = (state_ff == ST_SCORE) ? chain[HIDDEN_SIZE].col[AW-1:0]
                                             : ecol1_ff[AW-1:0];
   assign ss_wdata  = (state_ff == ST_SCORE) ? score_sat : 32'(e_val);
   assign ediff     = 33'(top_ff) - 33'($signed(ss_rdata));

   // Divider feed: round(E * 2^16 / S)
   always_comb begin
      div_in       = '0;
      div_in.valid = rd_v_ff && (state_ff == ST_PROB);
      div_in.col   = rd_col_ff;
      div_in.rem   = DIV_NW'({ss_rdata[16:0], 16'd0}) + DIV_NW'(total_ff >> 1);
   end

   assign p_val   = (total_ff == '0) ? '0 : div_out.q;
   assign err_val = (div_out.col == colt_ff) ? ERR_W'(p_val) - 18'sd65536
                                             : ERR_W'(p_val);

   // Item entering the head of the row: a score column or an error term
   always_comb begin
      inject_in       = '0;
      inject_in.score = (state_ff == ST_SCORE) && (cnt_ff < VCNT);
      inject_in.grad  = div_out.valid;
      inject_in.col   = div_out.valid ? div_out.col : COL_W'(cnt_ff);
      inject_in.err   = err_val;
   end

   // Sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Next state and broadcast controls
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.row      = row_ff;
      cmd.col_t    = colt_ff;
      cmd.e_t      = e_t_ff;
      cmd.lr       = lr_ff;
      cmd.clr_addr = COL_W'(cnt_ff);
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_we = 1'b1;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == VCNT - 1'b1) begin
               state_in = ST_IDLE;
               cnt_in   = '0;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               state_in = bad_word ? ST_DONE : ST_LOAD;
               cnt_in   = '0;
            end
         end
         ST_LOAD: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(1)) begin
               cmd.load_h  = 1'b1;
               cmd.clr_acc = 1'b1;
               state_in    = ST_SCORE;
               cnt_in      = '0;
            end
         end
         ST_SCORE, ST_EXP, ST_PROB: begin
            if (cnt_ff < VCNT) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if ((state_ff == ST_SCORE && score_done) ||
                (state_ff == ST_EXP && exp_done)) begin
               state_in = (state_ff == ST_SCORE) ? ST_EXP : ST_PROB;
               cnt_in   = '0;
            end else if (state_ff == ST_PROB && prob_done) begin
               state_in = ST_UPDATE;
               cnt_in   = '0;
            end
         end
         ST_UPDATE: begin
            cnt_in     = cnt_ff + 1'b1;
            cmd.mul_e  = (cnt_ff == CW'(0));
            cmd.rnd    = (cnt_ff == CW'(1));
            cmd.mul_lr = (cnt_ff == CW'(2));
            cmd.wr     = (cnt_ff == CW'(3));
            if (cnt_ff == UPD_END) begin
               state_in = ST_DONE;
               cnt_in   = '0;
            end
         end
         ST_DONE: begin
            if (take_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff        <= LR_RESET;
         rsp_valid_ff <= 1'b0;
         inject_ff    <= '0;
         rd_v_ff      <= 1'b0;
         ev1_ff       <= 1'b0;
      end else begin
         if (csr_we) begin
            lr_ff <= csr_wdata;
         end
         if (state_ff == ST_DONE && take_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         inject_ff <= inject_in;
         rd_v_ff <= (state_ff == ST_EXP || state_ff == ST_PROB) && (cnt_ff < VCNT);
         ev1_ff  <= rd_v_ff && (state_ff == ST_EXP);
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      rd_col_ff <= COL_W'(cnt_ff);
      ecol1_ff  <= rd_col_ff;
      if (accept) begin
         row_ff  <= COL_W'(req_payload.input_word);
         colt_ff <= COL_W'(req_payload.output_word);
         res_ff  <= '0;
      end
      if (state_ff == ST_LOAD) begin
         top_ff   <= SCORE_LOW;
         total_ff <= '0;
      end else if (state_ff == ST_SCORE && chain[HIDDEN_SIZE].score &&
                   score_sat > top_ff) begin
         top_ff <= score_sat;
      end else if (ev1_ff) begin
         total_ff <= total_ff + SUM_W'(e_val);
      end
      // exp(-d) = exp(-n) * exp(-k/16), zero from n = 12 on
      if (ediff[32:16] < 17'(EXP_N_LIMIT)) begin
         eprod_ff <= 34'(exp_whole(ediff[19:16])) * 34'(exp_frac(ediff[15:12]));
      end else begin
         eprod_ff <= '0;
      end
      if (div_out.valid && div_out.col == colt_ff) begin
         e_t_ff <= err_val;
      end
      if (state_ff == ST_UPDATE && cnt_ff == UPD_END) begin
         res_ff.positive_change_count    <= cnts[HIDDEN_SIZE].pos;
         res_ff.nonpositive_change_count <= cnts[HIDDEN_SIZE].neg;
      end
      if (state_ff == ST_DONE && take_rsp) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `WETS_ASSERT_IMP(a_clear_blocks_req, state_ff == ST_CLEAR, !req_ready)
   `WETS_ASSERT_NXT(a_accept_leaves_idle, accept, state_ff != ST_IDLE)
   `WETS_ASSERT_IMP(a_div_only_in_prob, div_out.valid, state_ff == ST_PROB)
   `WETS_ASSERT_IMP(a_score_only_in_score, chain[HIDDEN_SIZE].score, state_ff == ST_SCORE)
endmodule
